/* src/knt_pkg.sv */
// ----------------------------------------------------------------------------
// knt_pkg
// shared constants, register indexes and status codes of the k-nomial
// tree neighbor block
// ----------------------------------------------------------------------------
package knt_pkg;

  // default sizing
  localparam int RANK_BITS_DEF    = 16;
  localparam int MAX_CHILDREN_DEF = 63;

  // fixed field widths
  localparam int DEG_W     = 7;
  localparam int CAP_W     = 6;
  localparam int COUNT_W   = 6;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUP_SIZE     = 3'd0,
    CFG_TREE_DEGREE    = 3'd1,
    CFG_ROOT_RANK      = 3'd2,
    CFG_CHILD_ORDER    = 3'd3,
    CFG_CHILD_CAPACITY = 3'd4
  } cfg_idx_t;

  // summary status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // reset values of the registers
  localparam logic [DEG_W-1:0] DEG_RESET = 7'd2;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

endpackage

/* src/knt_in_if.sv */
// ----------------------------------------------------------------------------
// knt_in_if
// request channel: one rank per beat
// ----------------------------------------------------------------------------
interface knt_in_if #(
  parameter int RANK_BITS = knt_pkg::RANK_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [RANK_BITS-1:0] self_rank;

  modport source (output valid, output self_rank, input ready);
  modport sink   (input valid, input self_rank, output ready);
endinterface

/* src/knt_out_if.sv */
// ----------------------------------------------------------------------------
// knt_out_if
// result channel: child beats followed by one summary beat
// ----------------------------------------------------------------------------
interface knt_out_if #(
  parameter int RANK_BITS = knt_pkg::RANK_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         is_summary;
  logic [RANK_BITS-1:0]         child_rank;
  logic [knt_pkg::STATUS_W-1:0] status;
  logic                         parent_valid;
  logic [RANK_BITS-1:0]         parent_rank;
  logic [knt_pkg::COUNT_W-1:0]  child_count;
  logic                         last;

  modport source (output valid, output is_summary, output child_rank, output status,
                  output parent_valid, output parent_rank, output child_count,
                  output last, input ready);
  modport sink   (input valid, input is_summary, input child_rank, input status,
                  input parent_valid, input parent_rank, input child_count,
                  input last, output ready);
endinterface

/* src/knomial_tree_neighbors_top.sv */
// ----------------------------------------------------------------------------
// knomial_tree_neighbors_top
// parent and children of a rank in a k-nomial broadcast tree rotated to
// the configured root
// ----------------------------------------------------------------------------
//  channel   dir  handshake        per beat
//  in_ch     in   valid/ready      self_rank
//  out_ch    out  valid/ready      child beats then one summary beat (last)
//  cfg_*     in   cfg_we only      register index and data, no back-pressure
//
//  one rank at a time in the walker; the serial divider that finds each
//  base-k digit takes one quotient bit a cycle
//  a two-entry queue lets requests be taken while the walker or the
//  result register is busy; out_ch stalls hold the walker, and in_ch
//  once the queue is full
//  rst_n is synchronous; no clearing pass, the child store is only read
//  where it was just written
// ----------------------------------------------------------------------------
module knomial_tree_neighbors_top #(
  parameter int RANK_BITS    = knt_pkg::RANK_BITS_DEF,
  parameter int MAX_CHILDREN = knt_pkg::MAX_CHILDREN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  knt_in_if.sink                          in_ch,
  knt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [knt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [((RANK_BITS + 1 > knt_pkg::DEG_W) ?
                 RANK_BITS + 1 : knt_pkg::DEG_W)-1:0] cfg_data
);
  localparam int SW    = RANK_BITS + 1;
  localparam int DW    = knt_pkg::DEG_W;
  localparam int CW    = knt_pkg::CAP_W;
  localparam int CNT_W = $clog2(MAX_CHILDREN + 1);

  // configuration registers
  logic [SW-1:0]        group_size_r;
  logic [DW-1:0]        tree_degree_r;
  logic [RANK_BITS-1:0] root_rank_r;
  logic                 child_order_r;
  logic [CW-1:0]        child_capacity_r;

  // effective settings after clamping
  logic [SW-1:0]        size_eff;
  logic [DW-1:0]        deg_eff;
  logic [CNT_W-1:0]     cap_eff;

  // queue between front and walker
  logic                 q_push;
  logic [RANK_BITS:0]   q_wdata;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  logic [RANK_BITS:0]   q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r     <= SW'(1);
      tree_degree_r    <= knt_pkg::DEG_RESET;
      root_rank_r      <= '0;
      child_order_r    <= 1'b0;
      child_capacity_r <= knt_pkg::CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knt_pkg::CFG_GROUP_SIZE:     group_size_r     <= cfg_data[SW-1:0];
        knt_pkg::CFG_TREE_DEGREE:    tree_degree_r    <= cfg_data[DW-1:0];
        knt_pkg::CFG_ROOT_RANK:      root_rank_r      <= cfg_data[RANK_BITS-1:0];
        knt_pkg::CFG_CHILD_ORDER:    child_order_r    <= cfg_data[0];
        knt_pkg::CFG_CHILD_CAPACITY: child_capacity_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // group clamps to the rank space, degree of 0 or 1 acts as binary
  assign size_eff = (group_size_r > (SW'(1) << RANK_BITS)) ? (SW'(1) << RANK_BITS)
                                                           : group_size_r;
  assign deg_eff  = (tree_degree_r < DW'(2)) ? DW'(2) : tree_degree_r;
  assign cap_eff  = (child_capacity_r > CW'(MAX_CHILDREN)) ? CNT_W'(MAX_CHILDREN)
                                                            : CNT_W'(child_capacity_r);

  knt_front #(
    .RANK_BITS (RANK_BITS)
  ) u_front (
    .in_ch  (in_ch),
    .size   (size_eff),
    .root   (root_rank_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  knt_fifo #(
    .WIDTH (RANK_BITS + 1),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  knt_back #(
    .RANK_BITS    (RANK_BITS),
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .size    (size_eff),
    .root    (root_rank_r),
    .deg     (deg_eff),
    .order   (child_order_r),
    .cap     (cap_eff),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

/* src/knt_fifo.sv */
// ----------------------------------------------------------------------------
// knt_fifo
// short queue between the classifying front and the tree walker
// ----------------------------------------------------------------------------
module knt_fifo #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

/* src/knt_front.sv */
// ----------------------------------------------------------------------------
// knt_front
// takes request beats, checks rank and root against the group and
// rotates the rank into virtual-rank space before queueing it
// ----------------------------------------------------------------------------
module knt_front #(
  parameter int RANK_BITS = knt_pkg::RANK_BITS_DEF
) (
  knt_in_if.sink                in_ch,
  input  logic [RANK_BITS:0]    size,
  input  logic [RANK_BITS-1:0]  root,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [RANK_BITS:0]    q_data
);
  logic [RANK_BITS:0] self_ext;
  logic [RANK_BITS:0] root_ext;
  logic [RANK_BITS:0] vself_w;
  logic               bad;

  assign self_ext = {1'b0, in_ch.self_rank};
  assign root_ext = {1'b0, root};

  // out of range rank or root, also covers an empty group
  assign bad = (self_ext >= size) || (root_ext >= size);

  // (self - root) mod size with both below size
  assign vself_w = (self_ext >= root_ext) ? (self_ext - root_ext)
                                          : (self_ext + size - root_ext);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_data      = {bad, vself_w[RANK_BITS-1:0]};
endmodule

/* src/knt_back.sv */
// ----------------------------------------------------------------------------
// knt_back
// walks the tree for one queued rank: parent search with a serial
// divider, child generation into the scratch store, then result beats
// ----------------------------------------------------------------------------
module knt_back #(
  parameter int RANK_BITS    = knt_pkg::RANK_BITS_DEF,
  parameter int MAX_CHILDREN = knt_pkg::MAX_CHILDREN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [RANK_BITS:0]        size,
  input  logic [RANK_BITS-1:0]      root,
  input  logic [knt_pkg::DEG_W-1:0] deg,
  input  logic                      order,
  input  logic [$clog2(MAX_CHILDREN+1)-1:0] cap,
  input  logic                      q_valid,
  input  logic [RANK_BITS:0]        q_data,
  output logic                      q_pop,
  knt_out_if.source                 out_ch
);
  localparam int SW     = RANK_BITS + 1;
  localparam int DW     = knt_pkg::DEG_W;
  localparam int MW     = SW + DW;
  localparam int CNT_W  = $clog2(MAX_CHILDREN + 1);
  localparam int ADDR_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int LVL_W  = $clog2(RANK_BITS + 1);
  localparam int SIDX_W = $clog2(RANK_BITS);
  localparam int DCNT_W = $clog2(RANK_BITS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(RANK_BITS - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_PCHK  = 10'b00_0000_0010,
    S_PDIV  = 10'b00_0000_0100,
    S_PDEC  = 10'b00_0000_1000,
    S_PPAR  = 10'b00_0001_0000,
    S_CLVL  = 10'b00_0010_0000,
    S_CSTEP = 10'b00_0100_0000,
    S_ERD   = 10'b00_1000_0000,
    S_ELD   = 10'b01_0000_0000,
    S_SUM   = 10'b10_0000_0000
  } state_t;

  state_t                       state_r;
  logic [RANK_BITS-1:0]         vself_r;
  logic [RANK_BITS-1:0]         r_r;
  logic [DW-1:0]                rem_r;
  logic [DCNT_W-1:0]            dcnt_r;
  logic [MW-1:0]                mask_r;
  logic [LVL_W-1:0]             lvl_r;
  logic [RANK_BITS-1:0]         stack_r [RANK_BITS];
  logic [RANK_BITS-1:0]         prod_r;
  logic                         pv_r;
  logic [RANK_BITS-1:0]         pr_r;
  logic [knt_pkg::STATUS_W-1:0] status_r;
  logic [RANK_BITS-1:0]         cmask_r;
  logic [SW:0]                  v_r;
  logic [DW-1:0]                i_r;
  logic [CNT_W-1:0]             fill_r;
  logic [CNT_W-1:0]             k_r;
  logic [RANK_BITS-1:0]         mem [MAX_CHILDREN];
  logic [RANK_BITS-1:0]         rdata_r;

  logic                         o_valid_r;
  logic                         o_summ_r;
  logic [RANK_BITS-1:0]         o_child_r;
  logic [knt_pkg::STATUS_W-1:0] o_status_r;
  logic                         o_pv_r;
  logic [RANK_BITS-1:0]         o_pr_r;
  logic [CNT_W-1:0]             o_count_r;
  logic                         o_last_r;

  logic                         out_free;
  logic [DW:0]                  div_sh;
  logic                         div_q;
  logic [DW-1:0]                div_rem;
  logic [SW-1:0]                par_sum;
  logic [RANK_BITS-1:0]         par_rank;
  logic [LVL_W-1:0]             lvl_m1;
  logic [RANK_BITS-1:0]         stack_rd;
  logic [SW-1:0]                child_sum;
  logic [RANK_BITS-1:0]         child_val;
  logic                         step_go;
  logic                         step_full;
  logic [CNT_W-1:0]             rd_cnt;

  assign out_free = !o_valid_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // one restoring divide step of the running quotient by the degree
  assign div_sh  = {rem_r, r_r[RANK_BITS-1]};
  assign div_q   = (div_sh >= {1'b0, deg});
  assign div_rem = div_q ? DW'(div_sh - {1'b0, deg}) : div_sh[DW-1:0];

  // parent: clear the lowest nonzero digit, rotate back by the root
  assign par_sum  = {1'b0, vself_r - prod_r} + {1'b0, root};
  assign par_rank = (par_sum >= size) ? RANK_BITS'(par_sum - size)
                                      : par_sum[RANK_BITS-1:0];

  assign lvl_m1   = lvl_r - 1'b1;
  assign stack_rd = stack_r[lvl_m1[SIDX_W-1:0]];

  // child rank rotated back by the root
  assign child_sum = v_r[SW-1:0] + {1'b0, root};
  assign child_val = (child_sum >= size) ? RANK_BITS'(child_sum - size)
                                         : child_sum[RANK_BITS-1:0];
  assign step_go   = (i_r != deg) && (v_r < {1'b0, size});
  assign step_full = (fill_r >= cap);

  assign rd_cnt = order ? (fill_r - k_r - 1'b1) : k_r;

  // scratch store, one write and one registered read port
  always_ff @(posedge clk) begin
    if ((state_r == S_CSTEP) && step_go && !step_full) begin
      mem[fill_r[ADDR_W-1:0]] <= child_val;
    end
    if (state_r == S_ERD) begin
      rdata_r <= mem[rd_cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_PDEC) && (rem_r == '0)) begin
      stack_r[lvl_r[SIDX_W-1:0]] <= mask_r[RANK_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      o_valid_r <= 1'b0;
      fill_r    <= '0;
    end else begin
      if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            vself_r  <= q_data[RANK_BITS-1:0];
            r_r      <= q_data[RANK_BITS-1:0];
            mask_r   <= MW'(1);
            lvl_r    <= '0;
            pv_r     <= 1'b0;
            pr_r     <= '0;
            fill_r   <= '0;
            k_r      <= '0;
            status_r <= q_data[RANK_BITS] ? knt_pkg::ST_RANGE : knt_pkg::ST_OK;
            state_r  <= q_data[RANK_BITS] ? S_SUM : S_PCHK;
          end
        end
        S_PCHK: begin
          if (mask_r >= MW'(size)) begin
            state_r <= S_CLVL;
          end else begin
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_PDIV;
          end
        end
        S_PDIV: begin
          rem_r  <= div_rem;
          r_r    <= {r_r[RANK_BITS-2:0], div_q};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_LAST) begin
            state_r <= S_PDEC;
          end
        end
        S_PDEC: begin
          if (rem_r != '0) begin
            prod_r  <= RANK_BITS'(rem_r * mask_r[RANK_BITS-1:0]);
            state_r <= S_PPAR;
          end else begin
            lvl_r   <= lvl_r + 1'b1;
            mask_r  <= MW'(mask_r[RANK_BITS-1:0]) * MW'(deg);
            state_r <= S_PCHK;
          end
        end
        S_PPAR: begin
          pr_r    <= par_rank;
          pv_r    <= 1'b1;
          state_r <= S_CLVL;
        end
        S_CLVL: begin
          if (lvl_r == '0) begin
            k_r     <= '0;
            state_r <= S_ERD;
          end else begin
            lvl_r   <= lvl_m1;
            cmask_r <= stack_rd;
            v_r     <= (SW+1)'(vself_r) + (SW+1)'(stack_rd);
            i_r     <= DW'(1);
            state_r <= S_CSTEP;
          end
        end
        S_CSTEP: begin
          if (step_go) begin
            if (step_full) begin
              fill_r   <= '0;
              status_r <= knt_pkg::ST_TOO_SMALL;
              state_r  <= S_SUM;
            end else begin
              fill_r <= fill_r + 1'b1;
              v_r    <= v_r + (SW+1)'(cmask_r);
              i_r    <= i_r + 1'b1;
            end
          end else begin
            state_r <= S_CLVL;
          end
        end
        S_ERD: begin
          state_r <= (k_r == fill_r) ? S_SUM : S_ELD;
        end
        S_ELD: begin
          if (out_free) begin
            o_valid_r  <= 1'b1;
            o_summ_r   <= 1'b0;
            o_child_r  <= rdata_r;
            o_status_r <= knt_pkg::ST_OK;
            o_pv_r     <= 1'b0;
            o_pr_r     <= '0;
            o_count_r  <= '0;
            o_last_r   <= 1'b0;
            k_r        <= k_r + 1'b1;
            state_r    <= S_ERD;
          end
        end
        S_SUM: begin
          if (out_free) begin
            o_valid_r  <= 1'b1;
            o_summ_r   <= 1'b1;
            o_child_r  <= '0;
            o_status_r <= status_r;
            o_pv_r     <= pv_r;
            o_pr_r     <= pr_r;
            o_count_r  <= fill_r;
            o_last_r   <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.is_summary   = o_summ_r;
  assign out_ch.child_rank   = o_child_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.parent_valid = o_pv_r;
  assign out_ch.parent_rank  = o_pr_r;
  assign out_ch.child_count  = knt_pkg::COUNT_W'(o_count_r);
  assign out_ch.last         = o_last_r;
endmodule

/* tb/knomial_tree_neighbors_top_test.sv */
// ----------------------------------------------------------------------------
// knomial_tree_neighbors_top_test
// self-checking bench for the k-nomial tree neighbor block: ranks go in,
// a local tree walker predicts the child beats and the closing summary of
// each rank, and every result beat is compared against that prediction
// under changing tree settings and random idling on both channels
// ----------------------------------------------------------------------------
module knomial_tree_neighbors_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RB       = knt_pkg::RANK_BITS_DEF;
  localparam int MAX_KIDS = knt_pkg::MAX_CHILDREN_DEF;
  localparam int DEG_W    = knt_pkg::DEG_W;
  localparam int CAP_W    = knt_pkg::CAP_W;
  localparam int CFG_W    = (RB + 1 > DEG_W) ? RB + 1 : DEG_W;

  // receiver hold-off used to back up the block, and the quiet-cycle limit
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 20000;
  // settle time after the last expected beat, beyond the walker's tail
  localparam int DRAIN_CYCLES   = 20;

  // one result beat as the block presents it
  typedef struct packed {
    logic                         is_summary;
    logic [RB-1:0]                child_rank;
    logic [knt_pkg::STATUS_W-1:0] status;
    logic                         parent_valid;
    logic [RB-1:0]                parent_rank;
    logic [knt_pkg::COUNT_W-1:0]  child_count;
    logic                         last;
  } nbr_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [knt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  knt_in_if  #(.RANK_BITS(RB)) in_ch ();
  knt_out_if #(.RANK_BITS(RB)) out_ch ();

  knomial_tree_neighbors_top #(
    .RANK_BITS    (RB),
    .MAX_CHILDREN (MAX_KIDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the tree settings, starting at their reset values
  logic [CFG_W-1:0] tree_size     = 1;
  logic [DEG_W-1:0] tree_degree   = knt_pkg::DEG_RESET;
  logic [RB-1:0]    tree_root     = '0;
  logic             tree_reversed = 1'b0;
  logic [CAP_W-1:0] tree_capacity = knt_pkg::CAP_RESET;

  // beats still owed by the block, oldest first
  nbr_beat_t pending_beats[$];

  // idle mix of both sides, in percent of cycles
  int in_idle_pct  = 10;
  int out_idle_pct = 63;

  // long receiver hold-offs: requested by the tests, served by the receiver
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  // run tallies
  int fail_count   = 0;
  int ranks_taken  = 0;
  int child_beats  = 0;
  int ok_summaries = 0;
  int cap_overflows = 0;
  int range_errors = 0;
  int quiet_cycles = 0;

  nbr_beat_t got_beat;
  nbr_beat_t want_beat;
  logic      same;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // neighbor prediction: rotate to virtual ranks, find the parent by
  // clearing the lowest nonzero base-k digit, then collect children from
  // the largest power below the rank's own level downward
  // --------------------------------------------------------------------------
  function automatic void predict_neighbors(input logic [RB-1:0] rank);
    longint unsigned size, deg, root, cap, vself, mask, digit, v, i;
    logic [RB-1:0]   kids[$];
    logic            pv;
    logic [RB-1:0]   pr;
    nbr_beat_t       b;
    int              n;
    size = tree_size;
    if (size > (longint'(1) << RB)) size = longint'(1) << RB;
    deg  = (tree_degree < 2) ? 2 : tree_degree;
    root = tree_root;
    cap  = (tree_capacity < MAX_KIDS) ? tree_capacity : MAX_KIDS;
    pv   = 1'b0;
    pr   = '0;
    b    = '0;
    b.is_summary = 1'b1;
    b.last       = 1'b1;

    // rank or root outside the group: summary only
    if (rank >= size || root >= size) begin
      b.status = knt_pkg::ST_RANGE;
      pending_beats.push_back(b);
      return;
    end

    vself = (rank + size - root) % size;
    mask  = 1;
    while (mask < size) begin
      digit = vself % (deg * mask);
      if (digit != 0) begin
        pr = RB'(((vself - digit) + root) % size);
        pv = 1'b1;
        break;
      end
      mask = mask * deg;
    end
    mask = mask / deg;

    while (mask > 0) begin
      for (i = 1; i < deg; i++) begin
        v = vself + mask * i;
        if (v < size) begin
          // more children than the caller takes: no children at all
          if (kids.size() >= cap) begin
            b.status       = knt_pkg::ST_TOO_SMALL;
            b.parent_valid = pv;
            b.parent_rank  = pr;
            pending_beats.push_back(b);
            return;
          end
          kids.push_back(RB'((v + root) % size));
        end
      end
      mask = mask / deg;
    end

    n = kids.size();
    for (int k = 0; k < n; k++) begin
      nbr_beat_t c;
      c = '0;
      c.child_rank = tree_reversed ? kids[n-1-k] : kids[k];
      pending_beats.push_back(c);
    end
    b.status       = knt_pkg::ST_OK;
    b.parent_valid = pv;
    b.parent_rank  = pr;
    b.child_count  = knt_pkg::COUNT_W'(n);
    pending_beats.push_back(b);
  endfunction

  // every accepted rank queues its predicted beats
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_neighbors(in_ch.self_rank);
      ranks_taken++;
    end
  end

  // result checker: each beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat.is_summary   = out_ch.is_summary;
      got_beat.child_rank   = out_ch.child_rank;
      got_beat.status       = out_ch.status;
      got_beat.parent_valid = out_ch.parent_valid;
      got_beat.parent_rank  = out_ch.parent_rank;
      got_beat.child_count  = out_ch.child_count;
      got_beat.last         = out_ch.last;
      if (pending_beats.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: beat with nothing pending: summary=%0b child=%0d status=%0d",
                   $realtime, got_beat.is_summary, got_beat.child_rank, got_beat.status);
        fail_count++;
      end else begin
        want_beat = pending_beats.pop_front();
        same = (got_beat.is_summary   === want_beat.is_summary)   &&
               (got_beat.child_rank   === want_beat.child_rank)   &&
               (got_beat.status       === want_beat.status)       &&
               (got_beat.parent_valid === want_beat.parent_valid) &&
               (got_beat.parent_rank  === want_beat.parent_rank)  &&
               (got_beat.child_count  === want_beat.child_count)  &&
               (got_beat.last         === want_beat.last);
        if (!same) begin
          if (fail_count < 10) begin
            $display("%0t: mismatch, expected summary=%0b child=%0d status=%0d pv=%0b",
                     $realtime, want_beat.is_summary, want_beat.child_rank,
                     want_beat.status, want_beat.parent_valid);
            $display("  parent=%0d count=%0d last=%0b; got summary=%0b child=%0d status=%0d",
                     want_beat.parent_rank, want_beat.child_count, want_beat.last,
                     got_beat.is_summary, got_beat.child_rank, got_beat.status);
            $display("  pv=%0b parent=%0d count=%0d last=%0b",
                     got_beat.parent_valid, got_beat.parent_rank,
                     got_beat.child_count, got_beat.last);
          end
          fail_count++;
        end
        if (!got_beat.is_summary) child_beats++;
        else if (got_beat.status == knt_pkg::ST_OK) ok_summaries++;
        else if (got_beat.status == knt_pkg::ST_TOO_SMALL) cap_overflows++;
        else range_errors++;
      end
    end
  end

  // receiver: random ready, or a long hold-off when one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d beats still pending",
               $realtime, STALL_LIMIT, pending_beats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // shared stimulus tasks; all start and end at a falling edge
  // --------------------------------------------------------------------------

  // writes all five settings; only called while the block is idle
  task automatic write_config(input logic [CFG_W-1:0] size, input logic [DEG_W-1:0] deg,
                              input logic [RB-1:0] root, input logic reversed,
                              input logic [CAP_W-1:0] cap);
    tree_size     = size;
    tree_degree   = deg;
    tree_root     = root;
    tree_reversed = reversed;
    tree_capacity = cap;
    cfg_we    <= 1'b1;
    cfg_index <= knt_pkg::CFG_GROUP_SIZE;
    cfg_data  <= size;
    @(negedge clk);
    cfg_index <= knt_pkg::CFG_TREE_DEGREE;
    cfg_data  <= CFG_W'(deg);
    @(negedge clk);
    cfg_index <= knt_pkg::CFG_ROOT_RANK;
    cfg_data  <= CFG_W'(root);
    @(negedge clk);
    cfg_index <= knt_pkg::CFG_CHILD_ORDER;
    cfg_data  <= CFG_W'(reversed);
    @(negedge clk);
    cfg_index <= knt_pkg::CFG_CHILD_CAPACITY;
    cfg_data  <= CFG_W'(cap);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // offers one rank, with random sender gaps, until the block takes it;
  // valid stays up afterward so back-to-back ranks need no bubble
  task automatic send_rank(input logic [RB-1:0] rank);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.self_rank <= rank;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drops valid and waits until every predicted beat has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // settings straight out of reset: one-rank group
  task automatic test_reset_state();
    send_rank('0);                 // the root alone
    send_rank(RB'(1));             // just past the group
    send_rank('1);                 // top rank value
    wait_idle();
  endtask

  // ordinary trees: binary, rotated, reversed order, odd radix, full fan-out
  task automatic test_tree_shapes();
    write_config(16, 2, 0, 1'b0, 63);
    send_rank(0);
    send_rank(5);
    send_rank(15);
    wait_idle();
    write_config(16, 2, 5, 1'b1, 63);   // rotated, rightmost child first
    send_rank(5);
    send_rank(4);
    wait_idle();
    write_config(10, 3, 0, 1'b0, 63);   // ternary, ragged last level
    send_rank(0);
    send_rank(3);
    wait_idle();
    write_config(16, 0, 0, 1'b0, 63);   // degree zero acts as binary
    send_rank(0);
    wait_idle();
    write_config(16, 1, 3, 1'b0, 63);   // degree one acts as binary
    send_rank(3);
    wait_idle();
    write_config(64, 64, 0, 1'b0, 63);  // root with exactly the most children
    send_rank(0);
    send_rank(63);
    wait_idle();
  endtask

  // child capacity: overflow with and without a parent, exact fit, zero
  task automatic test_capacity_limits();
    write_config(16, 2, 0, 1'b0, 2);
    send_rank(0);
    send_rank(8);
    send_rank(12);
    wait_idle();
    write_config(16, 2, 0, 1'b1, 0);
    send_rank(15);                 // leaf still fits a zero capacity
    send_rank(0);
    wait_idle();
  endtask

  // empty group, root outside the group, oversized group and widest radix
  task automatic test_range_errors();
    write_config(0, 2, 0, 1'b0, 63);
    send_rank(0);
    wait_idle();
    write_config(10, 2, 12, 1'b0, 63);
    send_rank(3);
    wait_idle();
    write_config('1, 127, '1, 1'b0, 63);
    send_rank('1);
    send_rank(0);
    wait_idle();
    write_config(CFG_W'(1) << RB, 127, 0, 1'b0, 63);
    send_rank(0);
    send_rank(1);
    wait_idle();
  endtask

  // random settings in groups of twelve ranks under one idle mix
  task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items);
    int unsigned      size, span;
    logic [DEG_W-1:0] deg;
    logic [RB-1:0]    root;
    logic [CAP_W-1:0] cap;
    int               sent;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       size = $urandom_range(131071, 65536);
        1:       size = 65536;
        2:       size = $urandom_range(3, 0);
        3:       size = $urandom_range(65535, 1);
        default: size = $urandom_range(300, 2);
      endcase
      span = (size > 65536) ? 65536 : size;
      deg  = ($urandom_range(3) == 0) ? DEG_W'($urandom_range(127, 0))
                                       : DEG_W'($urandom_range(9, 2));
      root = (span == 0 || $urandom_range(9) == 0) ? RB'($urandom)
                                                    : RB'($urandom_range(span - 1, 0));
      case ($urandom_range(3))
        0:       cap = CAP_W'($urandom_range(63, 0));
        1:       cap = CAP_W'($urandom_range(4, 0));
        default: cap = CAP_W'(63);
      endcase
      write_config(CFG_W'(size), deg, root, 1'($urandom_range(1)), cap);
      repeat (12) begin
        // mostly ranks inside the group, now and then any 16-bit value
        send_rank((span == 0 || $urandom_range(9) == 0) ? RB'($urandom)
                                                         : RB'($urandom_range(span - 1, 0)));
        sent++;
      end
      wait_idle();
    end
  endtask

  // receiver holds off while ranks keep coming: the block fills and stalls
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_config(4096, 2, 0, 1'b0, 63);
    hold_requests++;
    repeat (10) send_rank(RB'($urandom_range(4095, 0)));
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = knt_pkg::CFG_GROUP_SIZE;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.self_rank = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part runs under the first idle mix
    test_reset_state();
    test_tree_shapes();
    test_capacity_limits();
    test_range_errors();

    test_random_traffic(10, 63, 48);
    test_random_traffic(63, 10, 48);
    test_random_traffic(0, 0, 48);
    test_backpressure();

    wait_idle();
    $display("covered %0d ranks: %0d child beats, %0d ok / %0d capacity / %0d range summaries",
             ranks_taken, child_beats, ok_summaries, cap_overflows, range_errors);
    $display("idle mixes 10/63, 63/10 and none, plus a %0d-cycle receiver hold; %0d failures",
             RX_HOLD_CYCLES, fail_count);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
